// File: hw/rtl/sfc_pkg.sv
// shared types and constants for the serial frame checker
`timescale 1ns / 1ps

package sfc_pkg;

	localparam int unsigned MAX_FRAME = 64;
	localparam int unsigned MIN_FRAME = 5;
	localparam int unsigned POS_W     = $clog2(MAX_FRAME + 1);

	localparam logic [7:0]  SYNC_BYTE = 8'h7E;
	localparam logic [3:0]  SEQ_DEST  = 4'h1;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_LEN = 3'd1,
		ST_BAD_SEQ = 3'd2,
		ST_NO_SYNC = 3'd3,
		ST_BAD_CRC = 3'd4
	} status_t;

	typedef struct packed {
		logic       valid;
		status_t    status;
		logic [7:0] frame_length;
		logic [3:0] seq_number;
	} result_t;

endpackage

// File: hw/rtl/sfc_if.sv
// stream interfaces for the byte input and the frame result output
`timescale 1ns / 1ps

interface sfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface sfc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] frame_length;
	logic [3:0] seq_number;

	modport source (output valid, output status, output frame_length, output seq_number,
		input ready);
	modport sink   (input valid, input status, input frame_length, input seq_number,
		output ready);
endinterface

// File: hw/rtl/sfc_crc16.sv
// one-byte update of the reflected ccitt crc-16
`timescale 1ns / 1ps

module sfc_crc16 (
	input  logic [15:0] crc,
	input  logic [7:0]  data_byte,
	output logic [15:0] crc_next
);

	logic [7:0]  d0;
	logic [7:0]  d1;
	logic [15:0] dw;

	always_comb begin
		d0       = data_byte ^ crc[7:0];
		d1       = d0 ^ {d0[3:0], 4'h0};
		dw       = {8'h00, d1};
		crc_next = {d1, crc[15:8]} ^ (dw >> 4) ^ (dw << 3);
	end

endmodule

// File: hw/rtl/sfc_tracker.sv
// frame position tracking, length check, crc accumulation and end-of-frame checks
`timescale 1ns / 1ps

module sfc_tracker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      data_byte,
	output sfc_pkg::result_t result
);

	logic                      in_frame_q;
	logic [7:0]                len_q;
	logic [sfc_pkg::POS_W-1:0] pos_q;
	logic [15:0]               crc_q;
	logic [3:0]                nib_q;
	logic                      seq_ok_q;
	logic [15:0]               rcrc_q;

	logic                      in_frame_d;
	logic [7:0]                len_d;
	logic [sfc_pkg::POS_W-1:0] pos_d;
	logic [15:0]               crc_d;
	logic [3:0]                nib_d;
	logic                      seq_ok_d;
	logic [15:0]               rcrc_d;

	logic [15:0] crc_in;
	logic [15:0] crc_upd;
	logic [7:0]  pos_ext;
	logic [7:0]  crc_end;
	logic [7:0]  lo_pos;

	assign crc_in = in_frame_q ? crc_q : sfc_pkg::CRC_INIT;

	sfc_crc16 u_crc (
		.crc       (crc_in),
		.data_byte (data_byte),
		.crc_next  (crc_upd)
	);

	assign pos_ext = 8'(pos_q);
	assign crc_end = len_q - 8'd3;
	assign lo_pos  = len_q - 8'd2;

	always_comb begin
		in_frame_d = in_frame_q;
		len_d      = len_q;
		pos_d      = pos_q;
		crc_d      = crc_q;
		nib_d      = nib_q;
		seq_ok_d   = seq_ok_q;
		rcrc_d     = rcrc_q;

		result.valid        = 1'b0;
		result.status       = sfc_pkg::ST_OK;
		result.frame_length = len_q;
		result.seq_number   = nib_q;

		if (!in_frame_q) begin
			if (data_byte < 8'(sfc_pkg::MIN_FRAME) || data_byte > 8'(sfc_pkg::MAX_FRAME)) begin
				// bad length: report at once, next byte is a new length
				result.valid        = 1'b1;
				result.status       = sfc_pkg::ST_BAD_LEN;
				result.frame_length = data_byte;
				result.seq_number   = 4'h0;
			end else begin
				in_frame_d = 1'b1;
				len_d      = data_byte;
				pos_d      = sfc_pkg::POS_W'(1);
				crc_d      = crc_upd;
				seq_ok_d   = 1'b0;
				nib_d      = 4'h0;
				rcrc_d     = 16'h0000;
			end
		end else if (pos_ext < crc_end) begin
			crc_d = crc_upd;
			if (pos_ext == 8'd1) begin
				seq_ok_d = (data_byte[7:4] == sfc_pkg::SEQ_DEST);
				nib_d    = data_byte[3:0];
			end
			pos_d = pos_q + 1'b1;
		end else if (pos_ext == crc_end) begin
			rcrc_d = {data_byte, 8'h00};
			pos_d  = pos_q + 1'b1;
		end else if (pos_ext == lo_pos) begin
			rcrc_d = {rcrc_q[15:8], data_byte};
			pos_d  = pos_q + 1'b1;
		end else begin
			// sync byte: first failing check wins
			result.valid = 1'b1;
			priority if (!seq_ok_q)
				result.status = sfc_pkg::ST_BAD_SEQ;
			else if (data_byte != sfc_pkg::SYNC_BYTE)
				result.status = sfc_pkg::ST_NO_SYNC;
			else if (rcrc_q != crc_q)
				result.status = sfc_pkg::ST_BAD_CRC;
			else
				result.status = sfc_pkg::ST_OK;
			in_frame_d = 1'b0;
			pos_d      = '0;
			crc_d      = sfc_pkg::CRC_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			len_q      <= 8'h00;
			pos_q      <= '0;
			crc_q      <= sfc_pkg::CRC_INIT;
			nib_q      <= 4'h0;
			seq_ok_q   <= 1'b0;
			rcrc_q     <= 16'h0000;
		end else if (fire) begin
			in_frame_q <= in_frame_d;
			len_q      <= len_d;
			pos_q      <= pos_d;
			crc_q      <= crc_d;
			nib_q      <= nib_d;
			seq_ok_q   <= seq_ok_d;
			rcrc_q     <= rcrc_d;
		end
	end

endmodule

// File: hw/rtl/serial_frame_checker_unit.sv
// top level of the serial frame checker: input register, tracker, result register
`timescale 1ns / 1ps

//  channel  | dir | payload                                        | item
//  ---------+-----+------------------------------------------------+---------------------------
//  stream   | in  | data_byte[7:0]                                 | one raw byte of the link
//  report   | out | status[2:0] frame_length[7:0] seq_number[3:0]  | one per frame or bad length
//
// one byte per cycle sustained unless the report stalls; a taken byte waits in the input
// register while the tracker works on it, and its result, if any, goes to the result register
// reset clears the input and result valid flags and puts the tracker out of frame
// with the crc at its initial value
// a stalled report holds the result register and every buffered byte, with or without a
// result; the input register still takes one byte, then ready drops until the report is taken
// the crc update and the end-of-frame checks sit between the two registers

module serial_frame_checker_unit (
	input  logic               clk,
	input  logic               arst_n,
	sfc_byte_if.sink           stream,
	sfc_result_if.source       report
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic                out_valid_q;
	sfc_pkg::status_t    status_q;
	logic [7:0]          length_q;
	logic [3:0]          seq_q;

	sfc_pkg::result_t    res;
	logic                advance;
	logic                take_in;

	// tracker consumes the buffered byte only when the result slot can take a result
	assign advance      = valid_s1 && (!out_valid_q || report.ready);
	assign stream.ready = !valid_s1 || advance;
	assign take_in      = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= stream.data_byte;
		end
	end

	sfc_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.data_byte (byte_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			status_q <= res.status;
			length_q <= res.frame_length;
			seq_q    <= res.seq_number;
		end
	end

	assign report.valid        = out_valid_q;
	assign report.status       = status_q;
	assign report.frame_length = length_q;
	assign report.seq_number   = seq_q;

endmodule

// File: verif/serial_frame_checker_unit_tb.sv
// self-checking testbench for the serial frame checker: framed bytes in, frame reports out
`timescale 1ns / 1ps

module serial_frame_checker_unit_tb;

	// watchdog limit in clock cycles, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 200000;
	// settling wait in clock cycles after the final drain, before the result is printed
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_LIMIT = 4000;

	typedef struct packed {
		sfc_pkg::status_t status;
		logic [7:0]       frame_length;
		logic [3:0]       seq_number;
	} frame_report_t;

	logic clk = 1'b0;
	logic arst_n;

	sfc_byte_if   stream_if ();
	sfc_result_if report_if ();

	serial_frame_checker_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.report (report_if)
	);

	always #5 clk = ~clk;

	// reports the frame tracker is still owed, oldest first
	frame_report_t pending_reports[$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;

	// idling controls, changed between tests
	bit source_gaps = 1'b0;
	int stall_level = 0;
	int ready_hold = 0;

	// frame tracker state, mirrors the block from reset on
	bit          tracking_frame = 1'b0;
	logic [7:0]  frame_len = 8'd0;
	logic [6:0]  next_index = 7'd0;
	logic [15:0] crc_acc = sfc_pkg::CRC_INIT;
	logic [3:0]  seq_nibble = 4'd0;
	bit          seq_ok = 1'b0;
	logic [15:0] crc_field = 16'd0;

	// one byte of the reflected ccitt crc (mcrf4xx form), no final xor
	function automatic logic [15:0] crc_mcrf4xx_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0]  d;
		logic [15:0] dw;
		d = b ^ crc[7:0];
		d = d ^ (d << 4);
		dw = {8'h00, d};
		return {d, crc[15:8]} ^ (dw >> 4) ^ (dw << 3);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit allow_zero);
		int r;
		r = $urandom_range(0, 99);
		if (allow_zero && r < 50)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		else
			return $urandom_range(15, 40);
	endfunction

	// advance the frame tracker by one taken byte and queue the report it owes, if any
	task automatic track_stream_byte(input logic [7:0] b);
		frame_report_t rpt;
		if (!tracking_frame) begin
			if (b < sfc_pkg::MIN_FRAME || b > sfc_pkg::MAX_FRAME) begin
				// bad length: reported at once, stay out of frame
				rpt.status = sfc_pkg::ST_BAD_LEN;
				rpt.frame_length = b;
				rpt.seq_number = 4'd0;
				pending_reports.insert(pending_reports.size(), rpt);
			end else begin
				tracking_frame = 1'b1;
				frame_len = b;
				next_index = 7'd1;
				crc_acc = crc_mcrf4xx_step(sfc_pkg::CRC_INIT, b);
				seq_ok = 1'b0;
				seq_nibble = 4'd0;
				crc_field = 16'd0;
			end
		end else if (next_index < frame_len - 3) begin
			// sequence byte and payload feed the crc
			crc_acc = crc_mcrf4xx_step(crc_acc, b);
			if (next_index == 7'd1) begin
				seq_ok = (b[7:4] == sfc_pkg::SEQ_DEST);
				seq_nibble = b[3:0];
			end
			next_index = next_index + 7'd1;
		end else if (next_index == frame_len - 3) begin
			crc_field[15:8] = b;
			next_index = next_index + 7'd1;
		end else if (next_index == frame_len - 2) begin
			crc_field[7:0] = b;
			next_index = next_index + 7'd1;
		end else begin
			// sync byte closes the frame; first fault in check order wins
			if (!seq_ok)
				rpt.status = sfc_pkg::ST_BAD_SEQ;
			else if (b != sfc_pkg::SYNC_BYTE)
				rpt.status = sfc_pkg::ST_NO_SYNC;
			else if (crc_field != crc_acc)
				rpt.status = sfc_pkg::ST_BAD_CRC;
			else
				rpt.status = sfc_pkg::ST_OK;
			rpt.frame_length = frame_len;
			rpt.seq_number = seq_nibble;
			pending_reports.insert(pending_reports.size(), rpt);
			tracking_frame = 1'b0;
			next_index = 7'd0;
			crc_acc = sfc_pkg::CRC_INIT;
		end
	endtask

	// every byte taken by the block feeds the tracker
	always @(posedge clk) begin
		if (arst_n && stream_if.valid && stream_if.ready)
			track_stream_byte(stream_if.data_byte);
	end

	// every report taken is checked against the oldest owed one
	always @(posedge clk) begin
		frame_report_t want;
		if (arst_n && report_if.valid && report_if.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report status %0d length %0d seq %0d", $time,
					report_if.status, report_if.frame_length, report_if.seq_number);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				if (report_if.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						report_if.status);
					mismatch_count++;
				end
				if (report_if.frame_length !== want.frame_length) begin
					$display("%0t: frame_length expected %0d got %0d", $time,
						want.frame_length, report_if.frame_length);
					mismatch_count++;
				end
				if (report_if.seq_number !== want.seq_number) begin
					$display("%0t: seq_number expected %0d got %0d", $time,
						want.seq_number, report_if.seq_number);
					mismatch_count++;
				end
			end
		end
	end

	// report side back-pressure: off, occasional, or heavy
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (stall_level != 0 && $urandom_range(0, 3) < stall_level) begin
			report_if.ready <= 1'b0;
			ready_hold = (stall_level > 1) ? pick_gap(1'b0) + $urandom_range(0, 10)
				: pick_gap(1'b0);
		end else begin
			report_if.ready <= 1'b1;
			ready_hold = $urandom_range(0, 8);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d reports still owed", $time, pending_reports.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// offer one byte and hold it until taken; valid stays high for a following byte
	task automatic send_byte(input logic [7:0] value);
		int gap;
		gap = source_gaps ? pick_gap(1'b1) : 0;
		if (gap > 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.data_byte <= value;
		@(posedge clk);
		while (!stream_if.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// build a whole frame with random payload; faults are injected on request
	task automatic send_frame(input logic [7:0] len, input logic [7:0] seq_byte,
		input bit corrupt_crc, input bit drop_sync);
		logic [7:0]  frame_bytes [0:255];
		logic [15:0] crc;
		logic [15:0] flip;
		int          n;
		n = len;
		frame_bytes[0] = len;
		frame_bytes[1] = seq_byte;
		for (int i = 2; i < n - 3; i++)
			frame_bytes[i] = 8'($urandom);
		crc = sfc_pkg::CRC_INIT;
		for (int i = 0; i < n - 3; i++)
			crc = crc_mcrf4xx_step(crc, frame_bytes[i]);
		if (corrupt_crc) begin
			do
				flip = 16'($urandom);
			while (flip == 16'd0);
			crc = crc ^ flip;
		end
		frame_bytes[n - 3] = crc[15:8];
		frame_bytes[n - 2] = crc[7:0];
		if (drop_sync) begin
			do
				frame_bytes[n - 1] = 8'($urandom);
			while (frame_bytes[n - 1] == sfc_pkg::SYNC_BYTE);
		end else begin
			frame_bytes[n - 1] = sfc_pkg::SYNC_BYTE;
		end
		for (int i = 0; i < n; i++)
			send_byte(frame_bytes[i]);
	endtask

	function automatic logic [7:0] good_seq();
		return {sfc_pkg::SEQ_DEST, 4'($urandom)};
	endfunction

	function automatic logic [7:0] bad_seq();
		logic [3:0] upper;
		do
			upper = 4'($urandom);
		while (upper == sfc_pkg::SEQ_DEST);
		return {upper, 4'($urandom)};
	endfunction

	// mostly short frames, a few mid-size, now and then the largest
	function automatic logic [7:0] pick_frame_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 8'($urandom_range(sfc_pkg::MIN_FRAME, 16));
		else if (r < 95)
			return 8'($urandom_range(17, sfc_pkg::MAX_FRAME - 1));
		else
			return 8'(sfc_pkg::MAX_FRAME);
	endfunction

	function automatic logic [7:0] pick_bad_length();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, sfc_pkg::MIN_FRAME - 1));
		else
			return 8'($urandom_range(sfc_pkg::MAX_FRAME + 1, 255));
	endfunction

	// one random frame or stray byte, mostly well formed
	task automatic send_random_unit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			send_frame(pick_frame_length(), good_seq(), 1'b0, 1'b0);
		else if (r < 73)
			send_frame(pick_frame_length(), bad_seq(), 1'b0, 1'b0);
		else if (r < 80)
			send_frame(pick_frame_length(), good_seq(), 1'b0, 1'b1);
		else if (r < 87)
			send_frame(pick_frame_length(), good_seq(), 1'b1, 1'b0);
		else if (r < 92)
			send_frame(pick_frame_length(), 8'($urandom), 1'($urandom), 1'($urandom));
		else
			send_byte(pick_bad_length());
	endtask

	// stop offering and wait until every owed report has arrived, with a bound
	task automatic drain_reports();
		int unsigned waited;
		stream_if.valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reports.size() != 0) begin
			$display("%0t: %0d reports never arrived", $time, pending_reports.size());
			mismatch_count++;
			pending_reports.delete();
		end
	endtask

	// shortest frames, a crc fault alone and the faults stacked, the field extremes as bad lengths
	task automatic test_directed();
		source_gaps = 1'b0;
		stall_level = 0;
		send_frame(8'(sfc_pkg::MIN_FRAME), {sfc_pkg::SEQ_DEST, 4'h0}, 1'b0, 1'b0);
		// bad sequence hides missing sync and crc mismatch
		send_frame(8'(sfc_pkg::MIN_FRAME), 8'hFF, 1'b1, 1'b1);
		send_byte(8'h00);
		send_byte(8'(sfc_pkg::MIN_FRAME - 1));
		send_byte(8'(sfc_pkg::MAX_FRAME + 1));
		send_byte(8'hFF);
		// missing sync hides crc mismatch
		send_frame(8'(sfc_pkg::MIN_FRAME), {sfc_pkg::SEQ_DEST, 4'hF}, 1'b1, 1'b1);
		send_frame(8'(sfc_pkg::MIN_FRAME), {sfc_pkg::SEQ_DEST, 4'h5}, 1'b1, 1'b0);
	endtask

	// back-to-back bytes with the report side always ready
	task automatic test_back_to_back();
		int unsigned stop_at;
		source_gaps = 1'b0;
		stall_level = 0;
		stop_at = bytes_sent + 80;
		send_frame(8'(sfc_pkg::MAX_FRAME), good_seq(), 1'b0, 1'b0);
		while (bytes_sent < stop_at)
			send_random_unit();
	endtask

	// random traffic with idling on both sides
	task automatic test_random_traffic();
		source_gaps = 1'b1;
		stall_level = 1;
		send_frame(8'(sfc_pkg::MAX_FRAME), bad_seq(), 1'b0, 1'b0);
		while (bytes_sent < 330)
			send_random_unit();
	endtask

	// sender goes quiet until every report is in, then picks up again
	task automatic test_pause_and_resume();
		source_gaps = 1'b1;
		stall_level = 1;
		repeat (3) send_random_unit();
		drain_reports();
		repeat (3) send_random_unit();
	endtask

	// report side stalls hard while bytes keep coming
	task automatic test_report_backpressure();
		source_gaps = 1'b0;
		stall_level = 2;
		while (bytes_sent < 450)
			send_random_unit();
	endtask

	initial begin
		arst_n <= 1'b0;
		stream_if.valid <= 1'b0;
		stream_if.data_byte <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_back_to_back();
		test_random_traffic();
		test_pause_and_resume();
		test_report_backpressure();

		drain_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: serial_frame_checker_unit.f
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_if.sv
hw/rtl/sfc_crc16.sv
hw/rtl/sfc_tracker.sv
hw/rtl/serial_frame_checker_unit.sv
verif/serial_frame_checker_unit_tb.sv
